FILE: rtl/core/wcdm_pkg.sv
// Package for the work/client dispatch matcher: shared types and constants.
// Used by wcdm_ctrl, wcdm_dp and work_client_dispatch_matcher. No dependencies.
package wcdm_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CLIENT_W = 16;
  localparam int JOB_W = 16;
  localparam int STAGE_W = 6;
  localparam int SPLIT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE = 2'd1;

  localparam logic [CLIENT_W-1:0] THRESHOLD_RESET = 16'd55;
  localparam logic [STAGE_W-1:0] STAGE_RESET = 6'd5;

  localparam logic KIND_WORK = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic [JOB_W-1:0]   job;
    logic [STAGE_W-1:0] stage;
    logic [SPLIT_W-1:0] split;
  } work_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } wcdm_state_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic take_hit;
    logic shift_step;
    logic enqueue;
    logic remove;
    logic load_out;
  } wcdm_cmd_t;

  typedef struct packed {
    logic hit;
    logic more;
    logic pend;
    logic out_busy;
  } wcdm_status_t;

endpackage

FILE: rtl/core/wcdm_ctrl.sv
// Controller state machine of the dispatch matcher.
// Depends on wcdm_pkg; drives commands to wcdm_dp and reads its status.
module wcdm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wcdm_pkg::wcdm_status_t st,
  output wcdm_pkg::wcdm_cmd_t    cmd
);

  wcdm_pkg::wcdm_state_t state_r;
  wcdm_pkg::wcdm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcdm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wcdm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = wcdm_pkg::ST_SCAN;
        end
      end
      wcdm_pkg::ST_SCAN: begin
        if (st.hit) begin
          state_nxt = wcdm_pkg::ST_SHIFT;
        end else if (!st.more) begin
          state_nxt = wcdm_pkg::ST_FINISH;
        end
      end
      wcdm_pkg::ST_SHIFT: begin
        if (!st.more && !st.pend) begin
          state_nxt = wcdm_pkg::ST_FINISH;
        end
      end
      wcdm_pkg::ST_FINISH: begin
        if (!st.out_busy) begin
          state_nxt = wcdm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wcdm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      wcdm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.start = in_valid;
      end
      wcdm_pkg::ST_SCAN: begin
        if (st.hit) begin
          cmd.take_hit = 1'b1;
          cmd.shift_step = 1'b1;
        end else if (st.more) begin
          cmd.scan_step = 1'b1;
        end else begin
          cmd.enqueue = 1'b1;
        end
      end
      wcdm_pkg::ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.remove = !st.more && !st.pend;
      end
      wcdm_pkg::ST_FINISH: begin
        cmd.load_out = !st.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/wcdm_dp.sv
// Datapath of the dispatch matcher: both queue memories, counts, scan pointer,
// configuration registers and the output register. Depends on wcdm_pkg.
module wcdm_dp #(
  parameter int WORK_QUEUE_DEPTH = 16,
  parameter int CLIENT_QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wcdm_pkg::wcdm_cmd_t                  cmd,
  output wcdm_pkg::wcdm_status_t               st,
  input  logic                                cfg_we,
  input  logic [wcdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wcdm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_kind,
  input  logic [wcdm_pkg::CLIENT_W-1:0]       in_client_id,
  input  logic [wcdm_pkg::JOB_W-1:0]          in_job_id,
  input  logic [wcdm_pkg::STAGE_W-1:0]        in_task_id,
  input  logic [wcdm_pkg::SPLIT_W-1:0]        in_split_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_dispatched,
  output logic [wcdm_pkg::CLIENT_W-1:0]       out_client,
  output logic [wcdm_pkg::JOB_W-1:0]          out_job,
  output logic [wcdm_pkg::STAGE_W-1:0]        out_task,
  output logic [wcdm_pkg::SPLIT_W-1:0]        out_split,
  output logic                                out_dropped
);

  localparam int WAW = $clog2(WORK_QUEUE_DEPTH);
  localparam int CAW = $clog2(CLIENT_QUEUE_DEPTH);
  localparam int WCW = $clog2(WORK_QUEUE_DEPTH + 1);
  localparam int CCW = $clog2(CLIENT_QUEUE_DEPTH + 1);
  localparam int IW = (WCW > CCW) ? WCW : CCW;

  wcdm_pkg::work_entry_t work_mem [WORK_QUEUE_DEPTH];
  logic [wcdm_pkg::CLIENT_W-1:0] client_mem [CLIENT_QUEUE_DEPTH];

  wcdm_pkg::work_entry_t          work_rd_r;
  logic [wcdm_pkg::CLIENT_W-1:0]  client_rd_r;

  logic [wcdm_pkg::CLIENT_W-1:0]  thr_r;
  logic [wcdm_pkg::STAGE_W-1:0]   stage_r;

  logic                           kind_r;
  logic [wcdm_pkg::CLIENT_W-1:0]  client_r;
  wcdm_pkg::work_entry_t          item_r;

  logic [WCW-1:0]                 wcnt_r;
  logic [CCW-1:0]                 ccnt_r;
  logic [IW-1:0]                  idx_r;
  logic [IW-1:0]                  wa_r;
  logic                           chk_r;
  logic                           pend_r;

  logic                           res_disp_r;
  logic [wcdm_pkg::CLIENT_W-1:0]  res_client_r;
  wcdm_pkg::work_entry_t          res_item_r;
  logic                           res_drop_r;

  logic                           out_valid_r;
  logic                           out_disp_r;
  logic [wcdm_pkg::CLIENT_W-1:0]  out_client_r;
  wcdm_pkg::work_entry_t          out_item_r;
  logic                           out_drop_r;

  logic [IW-1:0]                  srch_cnt;
  logic                           more;
  logic                           match;
  logic                           rd_issue;
  logic                           wfull;
  logic                           cfull;
  logic                           w_we;
  logic [WAW-1:0]                 w_wa;
  wcdm_pkg::work_entry_t          w_wd;
  logic                           c_we;
  logic [CAW-1:0]                 c_wa;
  logic [wcdm_pkg::CLIENT_W-1:0]  c_wd;

  assign srch_cnt = (kind_r == wcdm_pkg::KIND_WORK) ? IW'(ccnt_r) : IW'(wcnt_r);
  assign more = idx_r < srch_cnt;
  assign match = (kind_r == wcdm_pkg::KIND_WORK) ?
                 ((client_rd_r < thr_r) || (item_r.stage == stage_r)) :
                 ((client_r < thr_r) || (work_rd_r.stage == stage_r));
  assign rd_issue = (cmd.scan_step || cmd.shift_step) && more;
  assign wfull = (wcnt_r == WCW'(WORK_QUEUE_DEPTH));
  assign cfull = (ccnt_r == CCW'(CLIENT_QUEUE_DEPTH));

  assign st.hit = chk_r && match;
  assign st.more = more;
  assign st.pend = pend_r;
  assign st.out_busy = out_valid_r && out_stall;

  always_comb begin
    w_we = 1'b0;
    w_wa = wa_r[WAW-1:0];
    w_wd = work_rd_r;
    c_we = 1'b0;
    c_wa = wa_r[CAW-1:0];
    c_wd = client_rd_r;
    if (kind_r == wcdm_pkg::KIND_REQUEST) begin
      w_we = cmd.shift_step && pend_r;
      c_we = cmd.enqueue && !cfull;
      c_wa = ccnt_r[CAW-1:0];
      c_wd = client_r;
    end else begin
      c_we = cmd.shift_step && pend_r;
      w_we = cmd.enqueue && !wfull;
      w_wa = wcnt_r[WAW-1:0];
      w_wd = item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      work_mem[w_wa] <= w_wd;
    end
    if (rd_issue && kind_r == wcdm_pkg::KIND_REQUEST) begin
      work_rd_r <= work_mem[idx_r[WAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      client_mem[c_wa] <= c_wd;
    end
    if (rd_issue && kind_r == wcdm_pkg::KIND_WORK) begin
      client_rd_r <= client_mem[idx_r[CAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= wcdm_pkg::THRESHOLD_RESET;
      stage_r <= wcdm_pkg::STAGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcdm_pkg::REG_THRESHOLD: thr_r <= cfg_wdata;
        wcdm_pkg::REG_STAGE: stage_r <= cfg_wdata[wcdm_pkg::STAGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= in_kind;
      client_r <= in_client_id;
      item_r.job <= in_job_id;
      item_r.stage <= in_task_id;
      item_r.split <= in_split_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
      ccnt_r <= '0;
      idx_r <= '0;
      wa_r <= '0;
      chk_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx_r <= '0;
        chk_r <= 1'b0;
        pend_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        chk_r <= more;
        if (more) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.shift_step) begin
        pend_r <= more;
        if (more) begin
          idx_r <= idx_r + 1'b1;
          wa_r <= idx_r - 1'b1;
        end
      end
      if (kind_r == wcdm_pkg::KIND_REQUEST) begin
        if (cmd.remove) begin
          wcnt_r <= wcnt_r - 1'b1;
        end
        if (cmd.enqueue && !cfull) begin
          ccnt_r <= ccnt_r + 1'b1;
        end
      end else begin
        if (cmd.remove) begin
          ccnt_r <= ccnt_r - 1'b1;
        end
        if (cmd.enqueue && !wfull) begin
          wcnt_r <= wcnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      res_disp_r <= 1'b1;
      res_drop_r <= 1'b0;
      if (kind_r == wcdm_pkg::KIND_WORK) begin
        res_client_r <= client_rd_r;
        res_item_r <= item_r;
      end else begin
        res_client_r <= client_r;
        res_item_r <= work_rd_r;
      end
    end else if (cmd.enqueue) begin
      res_disp_r <= 1'b0;
      res_client_r <= '0;
      res_item_r <= '0;
      res_drop_r <= (kind_r == wcdm_pkg::KIND_WORK) ? wfull : cfull;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_disp_r <= res_disp_r;
      out_client_r <= res_client_r;
      out_item_r <= res_item_r;
      out_drop_r <= res_drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dispatched = out_disp_r;
  assign out_client = out_client_r;
  assign out_job = out_item_r.job;
  assign out_task = out_item_r.stage;
  assign out_split = out_item_r.split;
  assign out_dropped = out_drop_r;

endmodule

FILE: rtl/core/work_client_dispatch_matcher.sv
// An accepted item is registered and the other queue is searched entry by entry up to its
// fill (at most the queue depth); a match closes up that queue behind the taken entry, and
// no match queues the item or drops it if full, and out_stall can hold back the result.
// Throughput: one item at a time; the next item is accepted in the cycle after the result is
// registered, even while that result waits. The single read port of each queue memory,
// one entry per cycle for the search and for closing up the queue, sets this figure.
// Reset clears both queue counts, loads the registers with 55 and 5, and empties the output.
module work_client_dispatch_matcher #(
  parameter int WORK_QUEUE_DEPTH = 16,
  parameter int CLIENT_QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wcdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcdm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [wcdm_pkg::CLIENT_W-1:0]   in_client_id,
  input  logic [wcdm_pkg::JOB_W-1:0]      in_job_id,
  input  logic [wcdm_pkg::STAGE_W-1:0]    in_task_id,
  input  logic [wcdm_pkg::SPLIT_W-1:0]    in_split_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_dispatched,
  output logic [wcdm_pkg::CLIENT_W-1:0]   out_client,
  output logic [wcdm_pkg::JOB_W-1:0]      out_job,
  output logic [wcdm_pkg::STAGE_W-1:0]    out_task,
  output logic [wcdm_pkg::SPLIT_W-1:0]    out_split,
  output logic                            out_dropped
);

  wcdm_pkg::wcdm_cmd_t    cmd;
  wcdm_pkg::wcdm_status_t st;

  wcdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  wcdm_dp #(
    .WORK_QUEUE_DEPTH   (WORK_QUEUE_DEPTH),
    .CLIENT_QUEUE_DEPTH (CLIENT_QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_kind),
    .in_client_id   (in_client_id),
    .in_job_id      (in_job_id),
    .in_task_id     (in_task_id),
    .in_split_index (in_split_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dispatched (out_dispatched),
    .out_client     (out_client),
    .out_job        (out_job),
    .out_task       (out_task),
    .out_split      (out_split),
    .out_dropped    (out_dropped)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block accepted a transaction but did not go busy");

  a_disp_not_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_dispatched && out_dropped))
    else $error("result both dispatched and dropped");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dispatched) |->
      (out_client == '0 && out_job == '0 && out_task == '0 && out_split == '0))
    else $error("undispatched result carries nonzero fields");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule

FILE: tb/work_client_dispatch_matcher_tb.sv
// Self-checking testbench for work_client_dispatch_matcher: predicts every dispatch result
// from its own copy of both queues and registers, under random idling and stalls.
// Depends on wcdm_pkg and the work_client_dispatch_matcher RTL.
module work_client_dispatch_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORK_DEPTH = 16;
  localparam int CLIENT_DEPTH = 16;
  localparam int PHASE_ITEMS = 215;
  localparam int PHASES = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef logic [wcdm_pkg::CLIENT_W-1:0]   client_t;
  typedef logic [wcdm_pkg::JOB_W-1:0]      job_t;
  typedef logic [wcdm_pkg::STAGE_W-1:0]    stage_t;
  typedef logic [wcdm_pkg::SPLIT_W-1:0]    split_t;
  typedef logic [wcdm_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [wcdm_pkg::CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_SPARE_LO = 2'd2;
  localparam cfg_idx_t REG_SPARE_HI = 2'd3;

  localparam int BURST_WORK = 0;
  localparam int BURST_REQUEST = 1;
  localparam int BURST_MIXED = 2;

  typedef struct packed {
    logic    kind;
    client_t client;
    job_t    job;
    stage_t  stage;
    split_t  split;
  } dispatch_item_t;

  typedef struct packed {
    logic    dispatched;
    client_t client;
    job_t    job;
    stage_t  stage;
    split_t  split;
    logic    dropped;
  } dispatch_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_data_t cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = wcdm_pkg::KIND_WORK;
  client_t in_client_id = '0;
  job_t in_job_id = '0;
  stage_t in_task_id = '0;
  split_t in_split_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_dispatched;
  client_t out_client;
  job_t out_job;
  stage_t out_task;
  split_t out_split;
  logic out_dropped;

  dispatch_item_t item_backlog[$];
  dispatch_result_t dispatch_due[$];
  wcdm_pkg::work_entry_t queued_work[$];
  client_t waiting_clients[$];
  client_t threshold_model = wcdm_pkg::THRESHOLD_RESET;
  stage_t stage_model = wcdm_pkg::STAGE_RESET;

  dispatch_result_t seen;
  dispatch_result_t want;
  int gap_pct = 25;
  int mismatches = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stale_cycles = 0;

  work_client_dispatch_matcher #(
    .WORK_QUEUE_DEPTH(WORK_DEPTH),
    .CLIENT_QUEUE_DEPTH(CLIENT_DEPTH)
  ) dut (.*);

  always #1 clk = ~clk;

  function automatic bit may_take(client_t client, stage_t stage);
    return (client < threshold_model) || (stage == stage_model);
  endfunction

  function automatic dispatch_result_t match_item(dispatch_item_t it);
    dispatch_result_t r;
    wcdm_pkg::work_entry_t w;
    bit found;
    r = '0;
    found = 1'b0;
    w.job = it.job;
    w.stage = it.stage;
    w.split = it.split;
    if (it.kind == wcdm_pkg::KIND_WORK) begin
      for (int i = 0; i < waiting_clients.size() && !found; i++) begin
        if (may_take(waiting_clients[i], w.stage)) begin
          r.client = waiting_clients[i];
          waiting_clients.delete(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (queued_work.size() < WORK_DEPTH) queued_work.push_back(w);
        else r.dropped = 1'b1;
      end
    end else begin
      for (int i = 0; i < queued_work.size() && !found; i++) begin
        if (may_take(it.client, queued_work[i].stage)) begin
          w = queued_work[i];
          r.client = it.client;
          queued_work.delete(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (waiting_clients.size() < CLIENT_DEPTH) waiting_clients.push_back(it.client);
        else r.dropped = 1'b1;
      end
    end
    if (found) begin
      r.dispatched = 1'b1;
      r.job = w.job;
      r.stage = w.stage;
      r.split = w.split;
    end
    return r;
  endfunction

  function automatic void add_item(logic kind, client_t client, job_t job, stage_t stage,
                                   split_t split);
    dispatch_item_t it;
    it.kind = kind;
    it.client = client;
    it.job = job;
    it.stage = stage;
    it.split = split;
    item_backlog.push_back(it);
  endfunction

  function automatic client_t pick_client();
    if ($urandom_range(9, 0) == 0) return client_t'($urandom);
    if ($urandom_range(1, 0) == 0 && threshold_model != 0)
      return client_t'($urandom_range(int'(threshold_model) - 1, 0));
    return client_t'($urandom_range(65535, int'(threshold_model)));
  endfunction

  function automatic stage_t pick_stage();
    if ($urandom_range(9, 0) < 4) return stage_model;
    return stage_t'($urandom_range(63, 0));
  endfunction

  function automatic void add_burst(int mode, int len);
    logic kind;
    for (int k = 0; k < len; k++) begin
      if (mode == BURST_WORK) kind = wcdm_pkg::KIND_WORK;
      else if (mode == BURST_REQUEST) kind = wcdm_pkg::KIND_REQUEST;
      else kind = ($urandom_range(1, 0) != 0) ? wcdm_pkg::KIND_REQUEST : wcdm_pkg::KIND_WORK;
      add_item(kind, pick_client(), job_t'($urandom), pick_stage(), split_t'($urandom));
    end
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wcdm_pkg::REG_THRESHOLD: threshold_model = data;
      wcdm_pkg::REG_STAGE: stage_model = data[wcdm_pkg::STAGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (item_backlog.size() != 0 || dispatch_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input dispatch_result_t exp_r,
                               input dispatch_result_t got_r);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected disp=%0d client=%0d job=%0d task=%0d split=%0d drop=%0d",
               $realtime, what, exp_r.dispatched, exp_r.client, exp_r.job, exp_r.stage,
               exp_r.split, exp_r.dropped);
      $display("  got disp=%0d client=%0d job=%0d task=%0d split=%0d drop=%0d",
               got_r.dispatched, got_r.client, got_r.job, got_r.stage, got_r.split,
               got_r.dropped);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        dispatch_due.push_back(match_item(item_backlog.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          in_valid <= 1'b1;
          in_kind <= item_backlog[0].kind;
          in_client_id <= item_backlog[0].client;
          in_job_id <= item_backlog[0].job;
          in_task_id <= item_backlog[0].stage;
          in_split_index <= item_backlog[0].split;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_dispatched, out_client, out_job, out_task, out_split, out_dropped};
        if (dispatch_due.size() == 0) begin
          note_mismatch("transaction with nothing outstanding", '0, seen);
        end else begin
          want = dispatch_due.pop_front();
          if (seen !== want) note_mismatch("field mismatch", want, seen);
        end
      end
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        stale_cycles <= 0;
      end else if (stale_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        stale_cycles <= stale_cycles + 1;
      end
    end
  end

  initial begin
    client_t thr;
    stage_t stg;
    logic [9:0] upper;
    int mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: clients 55 and up are remote and only take stage 5.
    add_item(wcdm_pkg::KIND_REQUEST, 16'd0, 16'hFFFF, 6'd63, 8'hFF);
    add_item(wcdm_pkg::KIND_REQUEST, 16'hFFFF, 16'h0000, 6'd0, 8'h00);
    add_item(wcdm_pkg::KIND_WORK, 16'hFFFF, 16'd0, 6'd0, 8'd0);
    add_item(wcdm_pkg::KIND_WORK, 16'd0, 16'hFFFF, 6'd63, 8'hFF);
    add_item(wcdm_pkg::KIND_WORK, 16'd7, 16'd1, 6'd5, 8'd1);
    add_item(wcdm_pkg::KIND_WORK, 16'd0, 16'd2, 6'd0, 8'd2);
    add_item(wcdm_pkg::KIND_WORK, 16'd0, 16'd3, 6'd5, 8'd3);
    add_item(wcdm_pkg::KIND_WORK, 16'd0, 16'd4, 6'd1, 8'd4);
    add_item(wcdm_pkg::KIND_REQUEST, 16'd55, 16'd9, 6'd9, 8'd9);
    add_item(wcdm_pkg::KIND_REQUEST, 16'd54, 16'd0, 6'd0, 8'd0);
    add_item(wcdm_pkg::KIND_REQUEST, 16'd56, 16'd0, 6'd0, 8'd0);
    add_item(wcdm_pkg::KIND_REQUEST, 16'd1, 16'd0, 6'd0, 8'd0);
    add_item(wcdm_pkg::KIND_REQUEST, 16'd2, 16'd0, 6'd0, 8'd0);
    add_item(wcdm_pkg::KIND_REQUEST, 16'd3, 16'd0, 6'd0, 8'd0);
    add_item(wcdm_pkg::KIND_WORK, 16'd56, 16'd5, 6'd4, 8'd5);
    add_item(wcdm_pkg::KIND_WORK, 16'd3, 16'd6, 6'd5, 8'd6);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin thr = '0; stg = '0; end
        1: begin thr = '1; stg = '1; end
        2: begin thr = wcdm_pkg::THRESHOLD_RESET; stg = wcdm_pkg::STAGE_RESET; end
        4: begin thr = 16'd1; stg = stage_t'($urandom); end
        6: begin thr = client_t'($urandom_range(200, 2)); stg = stage_t'($urandom); end
        default: begin thr = client_t'($urandom); stg = stage_t'($urandom); end
      endcase
      if (ph == 0) begin
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, cfg_data_t'($urandom));
      end
      upper = 10'($urandom);
      write_reg(wcdm_pkg::REG_THRESHOLD, thr);
      write_reg(wcdm_pkg::REG_STAGE, {upper, stg});
      gap_pct = (ph == 2) ? 0 : 25;

      // Long one-sided bursts overflow both queues.
      if (ph == 0) begin
        add_burst(BURST_WORK, 40);
        add_burst(BURST_REQUEST, 40);
      end
      while (item_backlog.size() < PHASE_ITEMS) begin
        mode = int'($urandom_range(9, 0));
        if (mode < 2) add_burst(BURST_WORK, int'($urandom_range(24, 4)));
        else if (mode < 4) add_burst(BURST_REQUEST, int'($urandom_range(24, 4)));
        else add_burst(BURST_MIXED, int'($urandom_range(24, 4)));
      end
      if (ph == 3 || ph == 5) hold_requests++;
      wait_drained();
    end

    if (dispatch_due.size() != 0) begin
      mismatches += dispatch_due.size();
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
